[hdl/mitt_pkg.sv]
// ----------------------------------------------------------------------------
// mitt_pkg
// shared types and codes of the mac/ip timeout table
// ----------------------------------------------------------------------------
package mitt_pkg;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAN = 2'd2;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_FOUND    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_CLEANED  = 3'd4;

	localparam int unsigned INTERVAL_RESET = 5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] mac_addr;
		logic [31:0] ip_addr;
		logic [31:0] now;
	} mitt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] removed_count;
	} mitt_out_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_HASH,
		S_ADD_HEAD,
		S_ADD_WALK,
		S_ADD_ORDER,
		S_Q_HASH,
		S_Q_HEAD,
		S_Q_CMP,
		S_C_CHECK,
		S_C_EVAL,
		S_FINISH
	} state_t;

endpackage

[hdl/mac_ip_timeout_table_core.sv]
// ----------------------------------------------------------------------------
// mac_ip_timeout_table_core
// pool of timed (mac, ip) entries with hash bucket chains, a free list and
// an insertion order list for expiry, all links held in synchronous rams
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data (mitt_in_t)
// out      output     out_valid / out_ready out_data (mitt_out_t)
// cfg      input      cfg_wen               cfg_wdata (timeout interval)
//
// one beat at a time: add walks its bucket chain to the tail, query compares
// chain entries until a match, clean removes expired entries until an unexpired
// entry stops it, a drop or spare opcode goes straight to the result; the pipelined
// bucket modulo unit and the single link ram ports pace these operations
// after reset the bucket head ram is cleared, with in_ready low
// a waiting result in the output register does not block the next input beat
// ----------------------------------------------------------------------------
module mac_ip_timeout_table_core
	import mitt_pkg::*;
#(
	parameter int POOL_ENTRIES = 2048,
	parameter int BUCKETS      = 2039
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mitt_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output mitt_out_t   out_data,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int KW = 112 + BW;
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
	localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

	state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [47:0]   mac_q;
	logic [31:0]   ip_q;
	logic [31:0]   now_q;
	logic [LW-1:0] e_q;
	logic [LW-1:0] t_q;
	logic [BW-1:0] h_q;
	logic [11:0]   cnt_q;
	logic [2:0]    status_q;
	logic [LW-1:0] hw_q;
	logic [LW-1:0] free_q;
	logic [LW-1:0] oldest_q;
	logic [LW-1:0] newest_q;
	logic [31:0]   intv_q;
	logic [BW-1:0] clr_q;
	logic          out_valid_q;
	mitt_out_t     out_q;

	logic          accept;
	logic          mod_start;
	logic [31:0]   hash_sum;
	logic          mod_done;
	logic [BW-1:0] mod_rem;

	logic          key_we, key_re;
	logic [AW-1:0] key_waddr, key_raddr;
	logic [KW-1:0] key_wdata, key_rdata;
	logic          nb_we, nb_re;
	logic [AW-1:0] nb_waddr, nb_raddr;
	logic [LW-1:0] nb_wdata, nb_rdata;
	logic          pb_we, pb_re;
	logic [AW-1:0] pb_waddr, pb_raddr;
	logic [LW-1:0] pb_wdata, pb_rdata;
	logic          no_we, no_re;
	logic [AW-1:0] no_waddr, no_raddr;
	logic [LW-1:0] no_wdata, no_rdata;
	logic          bh_we, bh_re;
	logic [BW-1:0] bh_waddr, bh_raddr;
	logic [LW-1:0] bh_wdata, bh_rdata;

	logic [47:0]   rd_mac;
	logic [31:0]   rd_ip;
	logic [31:0]   rd_stamp;
	logic [BW-1:0] rd_bucket;
	logic [31:0]   age;
	logic          expired;
	logic          key_match;
	logic          out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign rd_mac    = key_rdata[KW-1 -: 48];
	assign rd_ip     = key_rdata[KW-49 -: 32];
	assign rd_stamp  = key_rdata[KW-81 -: 32];
	assign rd_bucket = key_rdata[BW-1:0];
	assign age       = now_q - rd_stamp;
	assign expired   = (age >= intv_q);
	assign key_match = (rd_mac == mac_q) && (rd_ip == ip_q);

	assign hash_sum  = {24'd0, in_data.mac_addr[15:8]} + {24'd0, in_data.mac_addr[7:0]}
		+ in_data.ip_addr;
	assign mod_start = accept && ((in_data.opcode == OP_QUERY) ||
		((in_data.opcode == OP_ADD) && (free_q != NIL)));

	mitt_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (hash_sum),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	mitt_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.re(key_re), .raddr(key_raddr), .rdata(key_rdata)
	);

	mitt_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_nb_ram (
		.clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
		.re(nb_re), .raddr(nb_raddr), .rdata(nb_rdata)
	);

	mitt_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_pb_ram (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
		.re(pb_re), .raddr(pb_raddr), .rdata(pb_rdata)
	);

	mitt_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_no_ram (
		.clk(clk), .we(no_we), .waddr(no_waddr), .wdata(no_wdata),
		.re(no_re), .raddr(no_raddr), .rdata(no_rdata)
	);

	mitt_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bh_ram (
		.clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
		.re(bh_re), .raddr(bh_raddr), .rdata(bh_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_BUCKET) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					priority if (in_data.opcode == OP_ADD && free_q == NIL) state_d = S_FINISH;
					else if (in_data.opcode == OP_ADD) state_d = S_ADD_HASH;
					else if (in_data.opcode == OP_QUERY) state_d = S_Q_HASH;
					else if (in_data.opcode == OP_CLEAN) state_d = S_C_CHECK;
					else state_d = S_FINISH;
				end
			end
			S_ADD_HASH: begin
				if (mod_done) state_d = S_ADD_HEAD;
			end
			S_ADD_HEAD: begin
				state_d = (bh_rdata == NIL) ? S_ADD_ORDER : S_ADD_WALK;
			end
			S_ADD_WALK: begin
				if (nb_rdata == NIL) state_d = S_ADD_ORDER;
			end
			S_ADD_ORDER: state_d = S_FINISH;
			S_Q_HASH: begin
				if (mod_done) state_d = S_Q_HEAD;
			end
			S_Q_HEAD: begin
				state_d = (bh_rdata == NIL) ? S_FINISH : S_Q_CMP;
			end
			S_Q_CMP: begin
				if (key_match || nb_rdata == NIL) state_d = S_FINISH;
			end
			S_C_CHECK: begin
				state_d = (oldest_q == NIL) ? S_FINISH : S_C_EVAL;
			end
			S_C_EVAL: begin
				state_d = expired ? S_C_CHECK : S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram port control
	always_comb begin
		key_we = 1'b0; key_re = 1'b0;
		key_waddr = e_q[AW-1:0]; key_raddr = '0;
		key_wdata = {mac_q, ip_q, now_q, mod_rem};
		nb_we = 1'b0; nb_re = 1'b0; nb_waddr = '0; nb_raddr = '0; nb_wdata = NIL;
		pb_we = 1'b0; pb_re = 1'b0; pb_waddr = '0; pb_raddr = '0; pb_wdata = NIL;
		no_we = 1'b0; no_re = 1'b0; no_waddr = '0; no_raddr = '0; no_wdata = NIL;
		bh_we = 1'b0; bh_re = 1'b0; bh_waddr = '0; bh_raddr = '0; bh_wdata = NIL;
		unique case (state_q)
			S_CLEAR: begin
				bh_we    = 1'b1;
				bh_waddr = clr_q;
			end
			S_IDLE: begin
				no_re    = accept && (in_data.opcode == OP_ADD);
				no_raddr = free_q[AW-1:0];
			end
			S_ADD_HASH: begin
				if (mod_done) begin
					key_we   = 1'b1;
					nb_we    = 1'b1;
					nb_waddr = e_q[AW-1:0];
					no_we    = 1'b1;
					no_waddr = e_q[AW-1:0];
					bh_re    = 1'b1;
					bh_raddr = mod_rem;
				end
			end
			S_ADD_HEAD: begin
				if (bh_rdata == NIL) begin
					bh_we    = 1'b1;
					bh_waddr = h_q;
					bh_wdata = e_q;
					pb_we    = 1'b1;
					pb_waddr = e_q[AW-1:0];
				end else begin
					nb_re    = 1'b1;
					nb_raddr = bh_rdata[AW-1:0];
				end
			end
			S_ADD_WALK: begin
				if (nb_rdata == NIL) begin
					nb_we    = 1'b1;
					nb_waddr = t_q[AW-1:0];
					nb_wdata = e_q;
					pb_we    = 1'b1;
					pb_waddr = e_q[AW-1:0];
					pb_wdata = t_q;
				end else begin
					nb_re    = 1'b1;
					nb_raddr = nb_rdata[AW-1:0];
				end
			end
			S_ADD_ORDER: begin
				no_we    = (newest_q != NIL);
				no_waddr = newest_q[AW-1:0];
				no_wdata = e_q;
			end
			S_Q_HASH: begin
				bh_re    = mod_done;
				bh_raddr = mod_rem;
			end
			S_Q_HEAD: begin
				key_re    = (bh_rdata != NIL);
				key_raddr = bh_rdata[AW-1:0];
				nb_re     = (bh_rdata != NIL);
				nb_raddr  = bh_rdata[AW-1:0];
			end
			S_Q_CMP: begin
				key_re    = !key_match && (nb_rdata != NIL);
				key_raddr = nb_rdata[AW-1:0];
				nb_re     = !key_match && (nb_rdata != NIL);
				nb_raddr  = nb_rdata[AW-1:0];
			end
			S_C_CHECK: begin
				key_re    = (oldest_q != NIL);
				key_raddr = oldest_q[AW-1:0];
				nb_re     = (oldest_q != NIL);
				nb_raddr  = oldest_q[AW-1:0];
				pb_re     = (oldest_q != NIL);
				pb_raddr  = oldest_q[AW-1:0];
				no_re     = (oldest_q != NIL);
				no_raddr  = oldest_q[AW-1:0];
			end
			S_C_EVAL: begin
				if (expired) begin
					// unlink from bucket chain
					nb_we    = (pb_rdata != NIL);
					nb_waddr = pb_rdata[AW-1:0];
					nb_wdata = nb_rdata;
					bh_we    = (pb_rdata == NIL);
					bh_waddr = rd_bucket;
					bh_wdata = nb_rdata;
					pb_we    = (nb_rdata != NIL);
					pb_waddr = nb_rdata[AW-1:0];
					pb_wdata = pb_rdata;
					// push onto free list
					no_we    = 1'b1;
					no_waddr = oldest_q[AW-1:0];
					no_wdata = free_q;
				end
			end
			S_FINISH: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hw_q        <= '0;
			free_q      <= '0;
			oldest_q    <= NIL;
			newest_q    <= NIL;
			intv_q      <= 32'(INTERVAL_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) intv_q <= cfg_wdata;
			if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
			if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_ADD_HASH: begin
					if (mod_done) begin
						if (e_q == hw_q) begin
							free_q <= e_q + LW'(1);
							hw_q   <= hw_q + LW'(1);
						end else begin
							free_q <= no_rdata;
						end
					end
				end
				S_ADD_ORDER: begin
					if (newest_q == NIL) oldest_q <= e_q;
					newest_q <= e_q;
				end
				S_C_EVAL: begin
					if (expired) begin
						oldest_q <= no_rdata;
						if (no_rdata == NIL) newest_q <= NIL;
						free_q <= oldest_q;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload and work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= in_data.opcode;
					mac_q  <= in_data.mac_addr;
					ip_q   <= in_data.ip_addr;
					now_q  <= in_data.now;
					e_q    <= free_q;
					cnt_q  <= '0;
					status_q <= (in_data.opcode == OP_ADD) ? ST_DROPPED : ST_NOTFOUND;
				end
			end
			S_ADD_HASH: begin
				if (mod_done) h_q <= mod_rem;
			end
			S_ADD_HEAD: t_q <= bh_rdata;
			S_ADD_WALK: t_q <= nb_rdata;
			S_ADD_ORDER: status_q <= ST_ADDED;
			S_Q_CMP: begin
				if (key_match) status_q <= ST_FOUND;
			end
			S_C_CHECK: status_q <= ST_CLEANED;
			S_C_EVAL: begin
				if (expired) cnt_q <= cnt_q + 12'd1;
			end
			S_FINISH: begin
				if (out_free) begin
					out_q.status        <= status_q;
					out_q.removed_count <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input taken during bucket clear");

	a_free_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= hw_q)
		else $error("free head beyond fill mark");

	a_order_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q == NIL) == (newest_q == NIL))
		else $error("order list ends disagree");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second beat taken while busy");

	a_clean_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C_EVAL) |-> (op_q == OP_CLEAN))
		else $error("expiry step outside a clean");

endmodule

[hdl/mitt_ram.sv]
// ----------------------------------------------------------------------------
// mitt_ram
// simple dual port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mitt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/mitt_mod.sv]
// ----------------------------------------------------------------------------
// mitt_mod
// bucket index unit, 32-bit value modulo the bucket count by reciprocal
// multiplication, pipelined through stages s1, s2 and s3
// ----------------------------------------------------------------------------
module mitt_mod #(
	parameter int BUCKETS = 2039
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            start,
	input  logic [31:0]                                     value,
	output logic                                            done,
	output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / BUCKETS);
	localparam logic [16:0] DIVISOR = 17'(BUCKETS);

	logic        vld_s1;
	logic        vld_s2;
	logic        done_s3;
	logic [31:0] val_s1;
	logic [31:0] val_s2;
	logic [32:0] quo_s2;
	logic [32:0] rem_s3;
	logic [64:0] prod;
	logic [49:0] back;
	logic [32:0] rem_fix;

	// estimate is the true quotient or one below, so one subtract corrects it
	assign prod    = 65'(val_s1) * 65'(RECIP);
	assign back    = 50'(quo_s2) * 50'(DIVISOR);
	assign rem_fix = (rem_s3 >= 33'(DIVISOR)) ? (rem_s3 - 33'(DIVISOR)) : rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			vld_s1  <= start;
			vld_s2  <= vld_s1;
			done_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) val_s1 <= value;
		val_s2 <= val_s1;
		quo_s2 <= prod[64:32];
		rem_s3 <= {1'b0, val_s2} - back[32:0];
	end

	assign done = done_s3;
	assign rem  = rem_fix[BW-1:0];

endmodule
